// ===== src/spfe_pkg.sv =====
// ----------------------------------------------------------------------------
// spfe_pkg
// Shared types, constants and the checksum fold of the frame encoder.
// ----------------------------------------------------------------------------
package spfe_pkg;

  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] SUM_BASE  = 8'hFF;

  localparam logic [7:0] FRAME_TYPE_RST = 8'h10;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [FRAME_BYTES-1:0]      esc;
  } frame_t;

  // Folding the carries of the plain byte total back in twice gives the same
  // value as adding the carry back after every byte.
  function automatic logic [7:0] fold_sum(input logic [10:0] total);
    logic [8:0] f;
    f = 9'(total[7:0]) + 9'(total[10:8]);
    return f[7:0] + 8'(f[8]);
  endfunction

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == ESC_BYTE) || (b == FLAG_BYTE);
  endfunction

endpackage

// ===== src/spfe_front.sv =====
// ----------------------------------------------------------------------------
// spfe_front
// Accepts a telemetry word, builds the eight frame bytes with their checksum
// and marks the bytes that need an escape.
// ----------------------------------------------------------------------------
module spfe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           frame_type_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          sensor_id_i,
  input  logic [31:0]          payload_i,
  output logic                 push_o,
  output spfe_pkg::frame_t     frame_o,
  input  logic                 fifo_full_i
);
  import spfe_pkg::*;

  logic   valid_q, valid_d;
  frame_t frame_q, frame_d;
  logic   load;
  logic [10:0] sum_all;

  assign push_o     = valid_q && !fifo_full_i;
  assign in_stall_o = valid_q && fifo_full_i;
  assign load       = in_valid_i && !in_stall_o;
  assign frame_o    = frame_q;

  always_comb begin
    frame_d.bytes[0] = frame_type_i;
    frame_d.bytes[1] = sensor_id_i[7:0];
    frame_d.bytes[2] = sensor_id_i[15:8];
    frame_d.bytes[3] = payload_i[7:0];
    frame_d.bytes[4] = payload_i[15:8];
    frame_d.bytes[5] = payload_i[23:16];
    frame_d.bytes[6] = payload_i[31:24];
    sum_all = ((11'(frame_d.bytes[0]) + 11'(frame_d.bytes[1])) +
               (11'(frame_d.bytes[2]) + 11'(frame_d.bytes[3]))) +
              ((11'(frame_d.bytes[4]) + 11'(frame_d.bytes[5])) +
               11'(frame_d.bytes[6]));
    frame_d.bytes[FRAME_BYTES-1] = SUM_BASE - fold_sum(sum_all);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      frame_d.esc[i] = needs_esc(frame_d.bytes[i]);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_d;
    end
  end

endmodule

// ===== src/spfe_fifo.sv =====
// ----------------------------------------------------------------------------
// spfe_fifo
// Short queue of prepared frames between the front and the serializer.
// ----------------------------------------------------------------------------
module spfe_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  spfe_pkg::frame_t frame_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output spfe_pkg::frame_t head_o
);
  import spfe_pkg::*;

  frame_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("frame queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("frame queue read while empty");

endmodule

// ===== src/spfe_back.sv =====
// ----------------------------------------------------------------------------
// spfe_back
// Serializes queued frames into an output register, one line byte per cycle
// unless out_stall_i holds it, inserting escape pairs.
// ----------------------------------------------------------------------------
module spfe_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fifo_valid_i,
  input  spfe_pkg::frame_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       line_byte_o,
  output logic             frame_end_o
);
  import spfe_pkg::*;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_end_q, out_end_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             esc_q, esc_d;
  logic             adv;
  logic [7:0]       cur;
  logic             last;

  assign adv  = fifo_valid_i && (!out_valid_q || !out_stall_i);
  assign cur  = head_i.bytes[idx_q];
  assign last = (idx_q == LAST_IDX);

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_end_d   = out_end_q;
    idx_d       = idx_q;
    esc_d       = esc_q;
    pop_o       = 1'b0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      out_valid_d = 1'b1;
      if (!esc_q && head_i.esc[idx_q]) begin
        out_byte_d = ESC_BYTE;
        out_end_d  = 1'b0;
        esc_d      = 1'b1;
      end else begin
        out_byte_d = esc_q ? (cur ^ ESC_XOR) : cur;
        out_end_d  = last;
        esc_d      = 1'b0;
        idx_d      = last ? '0 : idx_q + 1'b1;
        pop_o      = last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      esc_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      esc_q       <= esc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o = out_valid_q;
  assign line_byte_o = out_byte_q;
  assign frame_end_o = out_end_q;

  a_esc_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> (fifo_valid_i && head_i.esc[idx_q]))
    else $error("escape pending without an escaped byte at the head");

  a_esc_after_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && esc_d) |=> (out_valid_q && out_byte_q == ESC_BYTE && !out_end_q))
    else $error("escape marker not presented");

  a_pop_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && out_end_q && idx_q == '0))
    else $error("frame released without its last byte");

endmodule

// ===== src/smart_port_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// smart_port_frame_encoder
// Telemetry data-frame encoder: one id/value word in, one stuffed frame out.
// ----------------------------------------------------------------------------
// Each accepted word produces 8 to 16 line bytes: the frame type, the id and
// the value least significant byte first, and a one's-complement style
// checksum, with 0x7D and 0x7E sent as escape pairs. The last byte carries
// frame_end_o. The serializer emits one byte per cycle unless out_stall_i
// holds it; a two-entry frame queue lets the next word be accepted and
// prepared while the current frame is still going out. The frame type
// register is written through cfg_we_i and cfg_data_i and resets to 0x10.
module smart_port_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] sensor_id_i,
  input  logic [31:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  line_byte_o,
  output logic        frame_end_o
);
  import spfe_pkg::*;

  logic [7:0] frame_type_q;
  logic       push;
  logic       pop;
  logic       fifo_full;
  logic       fifo_valid;
  frame_t     front_frame;
  frame_t     head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_type_q <= FRAME_TYPE_RST;
    end else if (cfg_we_i) begin
      frame_type_q <= cfg_data_i;
    end
  end

  spfe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_type_i (frame_type_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sensor_id_i  (sensor_id_i),
    .payload_i    (payload_i),
    .push_o       (push),
    .frame_o      (front_frame),
    .fifo_full_i  (fifo_full)
  );

  spfe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (front_frame),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .head_o  (head)
  );

  spfe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_byte_o  (line_byte_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
